### hdl/hmd_pkg.sv
`default_nettype none

package hmd_pkg;

	localparam int NUM_BINS  = 1024;
	localparam int MAX_ITEMS = 1024;
	localparam int VALUE_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int BIN_AW    = $clog2(NUM_BINS);
	// Set tag width: the bin store is swept once every 2**EPOCH_W - 1 sets
	localparam int EPOCH_W   = 8;

	typedef logic [BIN_AW-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	localparam count_t MAX_CNT     = COUNT_W'(MAX_ITEMS);
	localparam epoch_t EPOCH_FIRST = EPOCH_W'(1);
	localparam epoch_t EPOCH_LAST  = {EPOCH_W{1'b1}};
	localparam addr_t  ADDR_LAST   = BIN_AW'(NUM_BINS - 1);

	// One word of the bin store: the set it belongs to and its count
	typedef struct packed {
		epoch_t tag;
		count_t count;
	} bin_word_t;

	typedef struct packed {
		logic      en;
		addr_t     addr;
		bin_word_t word;
	} bin_wr_t;

	// Item held in the read-modify-write stage
	typedef struct packed {
		logic  valid;
		logic  hit;
		addr_t addr;
		logic  last;
	} item_t;

	typedef struct packed {
		count_t max_count;
		count_t distinct_count;
		logic   set_done;
	} result_t;

endpackage

`default_nettype wire

### hdl/hmd_in_if.sv
`default_nettype none

interface hmd_in_if;
	logic                       valid;
	logic                       ready;
	logic [hmd_pkg::VALUE_W-1:0] value;
	logic                       last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

### hdl/hmd_out_if.sv
`default_nettype none

interface hmd_out_if;
	logic            valid;
	logic            ready;
	hmd_pkg::count_t max_count;
	hmd_pkg::count_t distinct_count;
	logic            set_done;

	modport source (output valid, output max_count, output distinct_count, output set_done,
		input ready);
	modport sink   (input valid, input max_count, input distinct_count, input set_done,
		output ready);
endinterface

`default_nettype wire

### hdl/hmd_bin_store.sv
`default_nettype none

module hmd_bin_store (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire hmd_pkg::addr_t     rd_addr,
	output hmd_pkg::bin_word_t      rd_word,
	input  wire hmd_pkg::bin_wr_t   wr,
	input  wire logic               sweep_start,
	output logic                    sweep_busy
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} sweep_state_t;

	sweep_state_t       state_q;
	hmd_pkg::addr_t     ptr_q;
	hmd_pkg::bin_word_t mem [hmd_pkg::NUM_BINS];

	logic               we;
	hmd_pkg::addr_t     wa;
	hmd_pkg::bin_word_t wd;

	assign sweep_busy = (state_q == ST_SWEEP);

	// Walk every entry once, writing tag zero, after reset and on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sweep_start) begin
						state_q <= ST_SWEEP;
						ptr_q   <= '0;
					end
				end
				ST_SWEEP: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == hmd_pkg::ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_SWEEP;
					ptr_q   <= '0;
				end
			endcase
		end
	end

	// Sweep owns the write port while it runs
	always_comb begin
		if (sweep_busy) begin
			we = 1'b1;
			wa = ptr_q;
			wd = '0;
		end else begin
			we = wr.en;
			wa = wr.addr;
			wd = wr.word;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/hmd_update.sv
`default_nettype none

module hmd_update (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hmd_pkg::item_t     item,
	input  wire hmd_pkg::bin_word_t rd_word,
	output hmd_pkg::bin_wr_t        wr,
	output hmd_pkg::result_t        res,
	output logic                    wrap
);

	hmd_pkg::epoch_t    epoch_q;
	hmd_pkg::count_t    max_q;
	hmd_pkg::count_t    dist_q;
	hmd_pkg::bin_wr_t   fwd_q;

	hmd_pkg::bin_word_t cur;
	hmd_pkg::count_t    old_cnt;
	hmd_pkg::count_t    new_cnt;
	hmd_pkg::count_t    max_n;
	hmd_pkg::count_t    dist_n;

	// Take the word written last cycle when it is the same bin
	always_comb begin
		if (fwd_q.en && (fwd_q.addr == item.addr)) begin
			cur = fwd_q.word;
		end else begin
			cur = rd_word;
		end
		old_cnt = (cur.tag == epoch_q) ? cur.count : '0;
		new_cnt = (old_cnt < hmd_pkg::MAX_CNT) ? hmd_pkg::count_t'(old_cnt + 1'b1) : old_cnt;

		dist_n = dist_q;
		max_n  = max_q;
		if (item.hit) begin
			if ((old_cnt == '0) && (dist_q < hmd_pkg::MAX_CNT)) begin
				dist_n = hmd_pkg::count_t'(dist_q + 1'b1);
			end
			if (new_cnt > max_q) begin
				max_n = new_cnt;
			end
		end

		wr.en       = item.valid && item.hit;
		wr.addr     = item.addr;
		wr.word.tag = epoch_q;
		wr.word.count = new_cnt;

		res.max_count      = max_n;
		res.distinct_count = dist_n;
		res.set_done       = item.last;

		wrap = item.valid && item.last && (epoch_q == hmd_pkg::EPOCH_LAST);
	end

	// Advance statistics; a closing beat clears them and moves to a fresh set tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= hmd_pkg::EPOCH_FIRST;
			max_q   <= '0;
			dist_q  <= '0;
			fwd_q   <= '0;
		end else begin
			fwd_q <= wr;
			if (item.valid) begin
				if (item.last) begin
					max_q   <= '0;
					dist_q  <= '0;
					epoch_q <= wrap ? hmd_pkg::EPOCH_FIRST : hmd_pkg::epoch_t'(epoch_q + 1'b1);
				end else begin
					max_q  <= max_n;
					dist_q <= dist_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/hmd_out_fifo.sv
`default_nettype none

module hmd_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hmd_pkg::result_t push_data,
	output logic [1:0]            level,
	output logic                  pop,
	hmd_out_if.source             result
);

	hmd_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       level_q;
	hmd_pkg::result_t head;

	assign level = level_q;
	assign pop   = result.valid && result.ready;
	assign head  = entry_q[rd_ptr_q];

	assign result.valid          = (level_q != 2'd0);
	assign result.max_count      = head.max_count;
	assign result.distinct_count = head.distinct_count;
	assign result.set_done       = head.set_done;

	// Track fill level and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Hold result beats
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hdl/histogram_mode_and_distinct_top.sv
// An accepted value is held in stage one; its result is then pushed into the output buffer.
// Throughput: one value per cycle while ready is high, repeats included (last write forwarded).
// The bin store is a single-port-write, registered-read memory; one read-modify-write per cycle.
// Reset is asynchronous and active low; it clears all statistics and starts a clearing sweep
// of every bin with ready low. The same sweep runs after every 255th closing value.
`default_nettype none

module histogram_mode_and_distinct_top (
	input  wire logic clk,
	input  wire logic arst_n,
	hmd_in_if.sink    sample,
	hmd_out_if.source result
);

	hmd_pkg::item_t     item_s1;
	hmd_pkg::bin_word_t rd_word;
	hmd_pkg::bin_wr_t   wr;
	hmd_pkg::result_t   res;
	logic               wrap;
	logic               sweep_busy;
	logic [1:0]         level;
	logic               pop;
	logic [1:0]         occ_after;
	logic               accept;
	logic               hit;

	// Accept only when the output buffer has room for everything in flight
	assign occ_after    = level + {1'b0, item_s1.valid} - {1'b0, pop};
	assign sample.ready = !sweep_busy && !wrap && (occ_after <= 2'd1);
	assign accept       = sample.valid && sample.ready;
	assign hit          = (32'(sample.value) < hmd_pkg::NUM_BINS);

	// Stage one: hold the item while its bin word is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept;
			item_s1.hit   <= hit;
			item_s1.addr  <= hmd_pkg::BIN_AW'(sample.value);
			item_s1.last  <= sample.last;
		end
	end

	hmd_bin_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept),
		.rd_addr     (hmd_pkg::BIN_AW'(sample.value)),
		.rd_word     (rd_word),
		.wr          (wr),
		.sweep_start (wrap),
		.sweep_busy  (sweep_busy)
	);

	hmd_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.rd_word (rd_word),
		.wr      (wr),
		.res     (res),
		.wrap    (wrap)
	);

	hmd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_s1.valid),
		.push_data (res),
		.level     (level),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

### hdl/hmd_checker.sv
`default_nettype none

module hmd_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire hmd_pkg::count_t max_count,
	input wire hmd_pkg::count_t distinct_count,
	input wire logic            set_done
);

	// Hold a stalled result beat
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(max_count) && $stable(distinct_count)
			&& $stable(set_done))
		else $error("result payload changed while stalled");

	// The distinct count is nonzero exactly when the max count is nonzero
	a_zero_together: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((max_count == '0) == (distinct_count == '0)))
		else $error("max and distinct disagree on an empty set");

	// Never report counts beyond saturation
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (max_count <= hmd_pkg::MAX_CNT) && (distinct_count <= hmd_pkg::MAX_CNT))
		else $error("count above item limit");

endmodule

bind histogram_mode_and_distinct_top hmd_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.max_count      (result.max_count),
	.distinct_count (result.distinct_count),
	.set_done       (result.set_done)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	typedef logic [hmd_pkg::VALUE_W-1:0] value_t;

	// One row of the directed table; typed rows carry their answer inline
	typedef struct packed {
		value_t          value;
		logic            last;
		logic            typed;
		hmd_pkg::count_t max_count;
		hmd_pkg::count_t distinct_count;
	} row_t;

	localparam int NUM_ROWS = 19;
	localparam row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
		// first set after reset: bottom and top bins, back-to-back repeats
		'{10'd0,    1'b0, 1'b1, 11'd1, 11'd1},
		'{10'd0,    1'b0, 1'b1, 11'd2, 11'd1},
		'{10'd1023, 1'b0, 1'b1, 11'd2, 11'd2},
		'{10'd1023, 1'b0, 1'b1, 11'd2, 11'd2},
		'{10'd1023, 1'b1, 1'b1, 11'd3, 11'd2},
		// statistics start afresh after a closing beat
		'{10'd1023, 1'b1, 1'b1, 11'd1, 11'd1},
		'{10'd0,    1'b1, 1'b1, 11'd1, 11'd1},
		// alternating pair of bins
		'{10'd5,    1'b0, 1'b1, 11'd1, 11'd1},
		'{10'd6,    1'b0, 1'b1, 11'd1, 11'd2},
		'{10'd5,    1'b0, 1'b1, 11'd2, 11'd2},
		'{10'd6,    1'b0, 1'b1, 11'd2, 11'd2},
		'{10'd5,    1'b0, 1'b1, 11'd3, 11'd2},
		'{10'd682,  1'b0, 1'b0, 11'd0, 11'd0},
		'{10'd341,  1'b1, 1'b0, 11'd0, 11'd0},
		'{10'd512,  1'b0, 1'b0, 11'd0, 11'd0},
		'{10'd511,  1'b0, 1'b0, 11'd0, 11'd0},
		'{10'd512,  1'b0, 1'b0, 11'd0, 11'd0},
		'{10'd512,  1'b0, 1'b0, 11'd0, 11'd0},
		'{10'd511,  1'b1, 1'b0, 11'd0, 11'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	int   errors;

	hmd_in_if  values_bus ();
	hmd_out_if stats_bus ();

	histogram_mode_and_distinct_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (values_bus),
		.result (stats_bus)
	);

	// Predicted bin store and running statistics of the current set
	hmd_pkg::count_t  bin_tally [hmd_pkg::NUM_BINS];
	hmd_pkg::count_t  peak;
	hmd_pkg::count_t  distinct_seen;
	hmd_pkg::result_t stats_expected [$];

	always #4 clk = ~clk;

	// Count one value, give the statistics it produces, clear on a closing beat
	function automatic hmd_pkg::result_t tally_value(input value_t v, input logic l);
		hmd_pkg::result_t r;
		if (int'(v) < hmd_pkg::NUM_BINS) begin
			if (bin_tally[v] == '0 && distinct_seen < hmd_pkg::MAX_CNT)
				distinct_seen++;
			if (bin_tally[v] < hmd_pkg::MAX_CNT)
				bin_tally[v]++;
			if (bin_tally[v] > peak)
				peak = bin_tally[v];
		end
		r = '{peak, distinct_seen, l};
		if (l) begin
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			peak = '0;
			distinct_seen = '0;
		end
		return r;
	endfunction

	// Offer one value, hold it until accepted, then queue its expected statistics
	task automatic send_value(input value_t v, input logic l, input logic typed,
			input hmd_pkg::result_t typed_res);
		hmd_pkg::result_t predicted;
		while (!calm && $urandom_range(99) < 16) begin
			values_bus.valid <= 1'b0;
			@(posedge clk);
		end
		values_bus.valid <= 1'b1;
		values_bus.value <= v;
		values_bus.last  <= l;
		do
			@(posedge clk);
		while (!values_bus.ready);
		predicted = tally_value(v, l);
		stats_expected = {stats_expected, (typed ? typed_res : predicted)};
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain;
		values_bus.valid <= 1'b0;
		while (stats_expected.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus
	initial begin : stimulus
		value_t hb;
		value_t base;
		value_t v;
		int     hits;
		int     sent;
		int     sets;
		int     len;
		logic   narrow;

		arst_n = 1'b0;
		calm = 1'b0;
		values_bus.valid = 1'b0;
		values_bus.value = '0;
		values_bus.last = 1'b0;
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		peak = '0;
		distinct_seen = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < NUM_ROWS; i++)
			send_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
				'{DIRECTED_ROWS[i].max_count, DIRECTED_ROWS[i].distinct_count,
				DIRECTED_ROWS[i].last});
		drain();

		// deep set: hammer one bin into saturation among scattered other bins
		hb = value_t'($urandom);
		hits = 0;
		while (hits < 1030) begin
			if ($urandom_range(15) == 0)
				send_value(value_t'($urandom), 1'b0, 1'b0, '0);
			else begin
				send_value(hb, 1'b0, 1'b0, '0);
				hits++;
			end
		end
		send_value(hb, 1'b1, 1'b0, '0);
		drain();

		// many short sets, each with even odds on a narrow bin pool to force repeats
		sent = 0;
		sets = 0;
		while (sent < 680) begin
			len = ($urandom_range(9) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			narrow = 1'($urandom_range(1));
			base = value_t'($urandom);
			calm = (sets >= 60 && sets < 100);
			for (int k = 0; k < len; k++) begin
				v = narrow ? value_t'(int'(base) + $urandom_range(3)) : value_t'($urandom);
				send_value(v, k == len - 1, 1'b0, '0);
			end
			sent += len;
			sets++;
		end
		calm = 1'b0;
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Result side: check each beat, stall at random, hold off once for a long stretch
	initial begin : receive
		hmd_pkg::result_t want;
		int               seen;
		int               hold;

		seen = 0;
		hold = 0;
		stats_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stats_bus.valid && stats_bus.ready) begin
				if (stats_expected.size() == 0) begin
					$error("result beat with no expected statistics");
					errors++;
				end else begin
					want = stats_expected.pop_front();
					if (stats_bus.max_count !== want.max_count) begin
						$error("max_count: expected %0d, got %0d", want.max_count,
							stats_bus.max_count);
						errors++;
					end
					if (stats_bus.distinct_count !== want.distinct_count) begin
						$error("distinct_count: expected %0d, got %0d", want.distinct_count,
							stats_bus.distinct_count);
						errors++;
					end
					if (stats_bus.set_done !== want.set_done) begin
						$error("set_done: expected %0d, got %0d", want.set_done,
							stats_bus.set_done);
						errors++;
					end
				end
				seen++;
				if (seen == 600)
					hold = 200;
			end
			if (hold > 0) begin
				hold--;
				stats_bus.ready <= 1'b0;
			end else
				stats_bus.ready <= calm || $urandom_range(99) >= 16;
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
